[hw/rtl/json_string_unescape_assert.svh]
// ----------------------------------------------------------------------------
// json_string_unescape_assert.svh
// assertion macros for the json string unescape block
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

`ifndef SYNTHESIS

// implication checked at every rising edge outside reset
`define JSU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds while reset is applied
`define JSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define JSU_ASSERT(lbl, clk, rst, prop, msg)
`define JSU_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[hw/rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// types, codes and helpers of the json string unescape block
// ----------------------------------------------------------------------------
package jsu_pkg;

   // decoder mode, one-hot
   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_STR  = 4'b0010,
      MODE_ESC  = 4'b0100,
      MODE_HEX  = 4'b1000
   } mode_type;

   // result kind
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_EXPECT_QUOTE = 3'd0;
   localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
   localparam logic [2:0] ERR_ESC_CUT      = 3'd2;
   localparam logic [2:0] ERR_BAD_ESC      = 3'd3;
   localparam logic [2:0] ERR_BAD_UNICODE  = 3'd4;
   localparam logic [2:0] ERR_NONE         = 3'd0;

   // utf-8 lead and continuation marks
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= "0" && c <= "9") begin
         h.value = 4'(c - 8'h30);
      end else if (c >= "a" && c <= "f") begin
         h.value = 4'(c - 8'h57);
      end else if (c >= "A" && c <= "F") begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

[hw/rtl/json_string_unescape.sv]
// ----------------------------------------------------------------------------
// json_string_unescape
// streaming decoder for one json string literal with utf-8 output of \u escapes
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one text byte per transaction in req_tdata; req_tlast
//   marks end of text (the byte is then ignored). leading whitespace is
//   skipped, an opening quote starts a string, escapes are decoded and a \u
//   escape comes out as 1 to 3 utf-8 bytes.
//   rsp channel carries one result per transaction: a data byte, a string
//   complete mark or an error code in rsp_tuser; rsp_tlast flags the last
//   result caused by one input byte.
//   path: an accepted byte is held in the input register, then its
//   results are loaded into the result group register, from which the
//   rsp port presents them.
//   throughput: one byte per cycle while rsp_tready is high and each byte
//   gives at most one result; a \u escape giving several utf-8 bytes holds
//   the input until its result group drains, one result per cycle while rsp_tready is high.
//   reset: back to idle, no pending results.
//   stall: when rsp_tready is low the result group holds and the input
//   register still takes one more byte before req_tready drops.
// ----------------------------------------------------------------------------
`include "json_string_unescape_assert.svh"

module json_string_unescape
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [4:0] rsp_tuser,   // [1:0] kind, [4:2] error_code
   output logic       rsp_tlast    // last
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // decoder state
   mode_type    mode_ff, mode_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [11:0] cp_ff, cp_in;

   // result group register
   logic [1:0]       rem_ff, rem_in;
   logic [2:0][7:0]  bytes_ff, bytes_in;
   logic [1:0]       kind_ff, kind_in;
   logic [2:0]       err_ff, err_in;

   logic adv, fire, rsp_take;

   // decode results
   logic [1:0]       dec_n;
   logic [2:0][7:0]  dec_bytes;
   logic [1:0]       dec_kind;
   logic [2:0]       dec_err;
   hex_type          hex;
   logic [15:0]      cp_full;

   assign rsp_take   = rsp_tvalid && rsp_tready;
   // group is free for the next item after this cycle
   assign adv        = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_tready);
   assign fire       = in_vld_ff && adv;
   assign req_tready = !in_vld_ff || adv;

   assign hex     = hex_decode(in_byte_ff);
   assign cp_full = {cp_ff, hex.value};

   always_comb begin
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      cp_in     = cp_ff;
      dec_n     = 2'd0;
      dec_bytes = '0;
      dec_kind  = KIND_DATA;
      dec_err   = ERR_NONE;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (!in_end_ff) begin
               if (in_byte_ff == "\"") begin
                  mode_in = MODE_STR;
               end else if (!(in_byte_ff == 8'h20 ||
                              (in_byte_ff >= 8'h09 && in_byte_ff <= 8'h0D))) begin
                  dec_n    = 2'd1;
                  dec_kind = KIND_ERROR;
                  dec_err  = ERR_EXPECT_QUOTE;
               end
            end
         end
         MODE_STR: begin
            if (in_end_ff) begin
               mode_in  = MODE_IDLE;
               dec_n    = 2'd1;
               dec_kind = KIND_ERROR;
               dec_err  = ERR_UNTERMINATED;
            end else if (in_byte_ff == "\"") begin
               mode_in  = MODE_IDLE;
               dec_n    = 2'd1;
               dec_kind = KIND_DONE;
            end else if (in_byte_ff == "\\") begin
               mode_in = MODE_ESC;
            end else begin
               dec_n        = 2'd1;
               dec_bytes[0] = in_byte_ff;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_STR;
            dec_n   = 2'd1;
            if (in_end_ff) begin
               mode_in  = MODE_IDLE;
               dec_kind = KIND_ERROR;
               dec_err  = ERR_ESC_CUT;
            end else begin
               case (in_byte_ff)
                  "\"", "\\", "/": dec_bytes[0] = in_byte_ff;
                  "b":             dec_bytes[0] = 8'h08;
                  "f":             dec_bytes[0] = 8'h0C;
                  "n":             dec_bytes[0] = 8'h0A;
                  "r":             dec_bytes[0] = 8'h0D;
                  "t":             dec_bytes[0] = 8'h09;
                  "u": begin
                     mode_in = MODE_HEX;
                     cnt_in  = 2'd0;
                     cp_in   = '0;
                     dec_n   = 2'd0;
                  end
                  default: begin
                     mode_in  = MODE_IDLE;
                     dec_kind = KIND_ERROR;
                     dec_err  = ERR_BAD_ESC;
                  end
               endcase
            end
         end
         MODE_HEX: begin
            if (in_end_ff || !hex.ok) begin
               mode_in  = MODE_IDLE;
               cnt_in   = 2'd0;
               cp_in    = '0;
               dec_n    = 2'd1;
               dec_kind = KIND_ERROR;
               dec_err  = ERR_BAD_UNICODE;
            end else if (cnt_ff != 2'd3) begin
               cnt_in = cnt_ff + 2'd1;
               cp_in  = cp_full[11:0];
            end else begin
               mode_in = MODE_STR;
               cnt_in  = 2'd0;
               cp_in   = '0;
               if (cp_full[15:7] == '0) begin
                  dec_n        = 2'd1;
                  dec_bytes[0] = cp_full[7:0];
               end else if (cp_full[15:11] == '0) begin
                  dec_n        = 2'd2;
                  dec_bytes[0] = UTF8_LEAD2 | {3'b000, cp_full[10:6]};
                  dec_bytes[1] = UTF8_CONT | {2'b00, cp_full[5:0]};
               end else begin
                  dec_n        = 2'd3;
                  dec_bytes[0] = UTF8_LEAD3 | {4'b0000, cp_full[15:12]};
                  dec_bytes[1] = UTF8_CONT | {2'b00, cp_full[11:6]};
                  dec_bytes[2] = UTF8_CONT | {2'b00, cp_full[5:0]};
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            cnt_in  = 2'd0;
            cp_in   = '0;
         end
      endcase
   end

   // result group: load on fire, else drain one per taken transaction
   always_comb begin
      rem_in   = rem_ff;
      bytes_in = bytes_ff;
      kind_in  = kind_ff;
      err_in   = err_ff;
      if (fire) begin
         rem_in   = dec_n;
         bytes_in = dec_bytes;
         kind_in  = dec_kind;
         err_in   = dec_err;
      end else if (rsp_take) begin
         rem_in   = rem_ff - 2'd1;
         bytes_in = {8'h00, bytes_ff[2], bytes_ff[1]};
      end
   end

   assign in_vld_in = req_tready ? req_tvalid : in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         mode_ff   <= MODE_IDLE;
         cnt_ff    <= 2'd0;
         cp_ff     <= '0;
         rem_ff    <= 2'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         rem_ff    <= rem_in;
         if (fire) begin
            mode_ff <= mode_in;
            cnt_ff  <= cnt_in;
            cp_ff   <= cp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      bytes_ff <= bytes_in;
      kind_ff  <= kind_in;
      err_ff   <= err_in;
   end

   assign rsp_tvalid = (rem_ff != 2'd0);
   assign rsp_tdata  = bytes_ff[0];
   assign rsp_tuser  = {err_ff, kind_ff};
   assign rsp_tlast  = (rem_ff == 2'd1);

   // completion and error results stand alone
   `JSU_ASSERT(a_ctrl_single, clock, reset,
      (rsp_tvalid && kind_ff != KIND_DATA) |-> rsp_tlast, "control result not last")
   // a held input item keeps its byte
   `JSU_ASSERT(a_in_hold, clock, reset,
      (in_vld_ff && !adv) |=> (in_vld_ff && $stable(in_byte_ff)), "input item lost")
   // digit count only moves inside a \u escape
   `JSU_ASSERT(a_cnt_hex, clock, reset,
      (mode_ff != MODE_HEX) |-> (cnt_ff == 2'd0), "hex count outside escape")
   // a three-result group is a three-byte utf-8 sequence
   `JSU_ASSERT(a_utf8_lead, clock, reset,
      (rem_ff == 2'd3) |-> (bytes_ff[0][7:4] == 4'hE && kind_ff == KIND_DATA),
      "bad utf-8 lead")
   // no result pending right after reset
   `JSU_ASSERT_ALWAYS(a_reset_empty, clock,
      (!reset && $past(reset)) |-> !rsp_tvalid, "results pending after reset")

endmodule

[verif/json_string_unescape_tb.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_tb
// self-checking bench for the json string unescape block: a directed text
// walks broken escapes, a three-byte \u escape and every error path, then random
// strings with random content and broken escapes follow; a scoreboard
// predicts each result transaction and compares it field by field
// ----------------------------------------------------------------------------
module json_string_unescape_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jsu_pkg::*;

   localparam int NUM_ITEMS   = 430;
   localparam int QUIET_AFTER = 370;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 12;
   localparam logic [8:0] EOT = 9'h100;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic [2:0] code;
      logic       last;
   } decoded_type;

   class decode_scoreboard_type;
      decoded_type decoded_q[$];
      mode_type   state;
      logic [1:0] digit_cnt;
      logic [15:0] code_pt;
      int         errors;
      int         checked;
      int         completions;
      int         error_results;

      function new();
         state     = MODE_IDLE;
         digit_cnt = '0;
         code_pt   = '0;
         errors    = 0;
      endfunction

      static function int hex_nibble(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c) - 48;
         if (c >= "a" && c <= "f") return int'(c) - 87;
         if (c >= "A" && c <= "F") return int'(c) - 55;
         return -1;
      endfunction

      function void push(logic [7:0] d, logic [1:0] k, logic [2:0] e);
         decoded_type r;
         r.data = d;
         r.kind = k;
         r.code = e;
         r.last = 1'b0;
         decoded_q = {decoded_q, r};
      endfunction

      function void abort(logic [2:0] e);
         state     = MODE_IDLE;
         digit_cnt = '0;
         code_pt   = '0;
         push(8'h00, KIND_ERROR, e);
      endfunction

      // accepted request transaction: work out its results
      function void note_byte(logic [7:0] c, logic eot);
         int before_cnt;
         int nib;
         logic [15:0] cp;
         before_cnt = decoded_q.size();
         case (state)
            MODE_IDLE: begin
               if (!eot) begin
                  if (c == "\"") state = MODE_STR;
                  else if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) abort(ERR_EXPECT_QUOTE);
               end
            end
            MODE_STR: begin
               if (eot) abort(ERR_UNTERMINATED);
               else if (c == "\"") begin
                  state = MODE_IDLE;
                  push(8'h00, KIND_DONE, ERR_NONE);
               end else if (c == "\\") state = MODE_ESC;
               else push(c, KIND_DATA, ERR_NONE);
            end
            MODE_ESC: begin
               if (eot) abort(ERR_ESC_CUT);
               else begin
                  state = MODE_STR;
                  case (c)
                     "\"", "\\", "/": push(c, KIND_DATA, ERR_NONE);
                     "b": push(8'h08, KIND_DATA, ERR_NONE);
                     "f": push(8'h0C, KIND_DATA, ERR_NONE);
                     "n": push(8'h0A, KIND_DATA, ERR_NONE);
                     "r": push(8'h0D, KIND_DATA, ERR_NONE);
                     "t": push(8'h09, KIND_DATA, ERR_NONE);
                     "u": begin
                        state     = MODE_HEX;
                        digit_cnt = '0;
                        code_pt   = '0;
                     end
                     default: abort(ERR_BAD_ESC);
                  endcase
               end
            end
            default: begin
               nib = hex_nibble(c);
               if (eot || nib < 0) abort(ERR_BAD_UNICODE);
               else begin
                  code_pt = {code_pt[11:0], 4'(nib)};
                  if (digit_cnt != 2'd3) digit_cnt++;
                  else begin
                     cp        = code_pt;
                     digit_cnt = '0;
                     code_pt   = '0;
                     state     = MODE_STR;
                     if (cp <= 16'h007F) push(cp[7:0], KIND_DATA, ERR_NONE);
                     else if (cp <= 16'h07FF) begin
                        push(UTF8_LEAD2 | {3'b000, cp[10:6]}, KIND_DATA, ERR_NONE);
                        push(UTF8_CONT | {2'b00, cp[5:0]}, KIND_DATA, ERR_NONE);
                     end else begin
                        push(UTF8_LEAD3 | {4'h0, cp[15:12]}, KIND_DATA, ERR_NONE);
                        push(UTF8_CONT | {2'b00, cp[11:6]}, KIND_DATA, ERR_NONE);
                        push(UTF8_CONT | {2'b00, cp[5:0]}, KIND_DATA, ERR_NONE);
                     end
                  end
               end
            end
         endcase
         if (decoded_q.size() > before_cnt) decoded_q[decoded_q.size() - 1].last = 1'b1;
      endfunction

      function void field_check(string name, int exp_v, int got_v);
         if (exp_v != got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
         end
      endfunction

      // accepted response transaction: compare with the oldest prediction
      function void check_result(logic [7:0] d, logic [4:0] user, logic last);
         decoded_type exp_r;
         if (decoded_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual data %02h user %02h last %0b",
                     $time, d, user, last);
            return;
         end
         exp_r = decoded_q.pop_front();
         checked++;
         if (exp_r.kind == KIND_DONE) completions++;
         if (exp_r.kind == KIND_ERROR) error_results++;
         field_check("out_byte", exp_r.data, d);
         field_check("kind", exp_r.kind, user[1:0]);
         field_check("error_code", exp_r.code, user[4:2]);
         field_check("last", exp_r.last, last);
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       req_tlast = 1'b0;    // end_of_text
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic [4:0] rsp_tuser;           // [1:0] kind, [4:2] error_code
   logic       rsp_tlast;           // last

   decode_scoreboard_type sb = new();
   int  bytes_sent = 0;
   int  stall_cnt = 0;
   bit  quiet = 1'b0;

   json_string_unescape u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // entered and left at a falling edge
   task automatic send_byte(logic [7:0] b, logic eot);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= eot ? 8'($urandom) : b;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(req_tdata, req_tlast);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 10) return 8'h30 + nib;
      return 8'((($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + nib - 8'd10);
   endfunction

   function automatic bit is_escape_letter(logic [7:0] c);
      return c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" || c == "n" ||
             c == "r" || c == "t" || c == "u";
   endfunction

   task automatic send_unicode();
      logic [15:0] cp;
      case ($urandom_range(0, 2))
         0: cp = 16'($urandom_range(0, 16'h007F));
         1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
         default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
      endcase
      send_byte("\\", 1'b0);
      send_byte("u", 1'b0);
      for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[i*4 +: 4]), 1'b0);
   endtask

   // broken escape: the block drops back to idle afterwards
   task automatic send_broken_escape();
      logic [7:0] b;
      int ndig;
      send_byte("\\", 1'b0);
      case ($urandom_range(0, 3))
         0: begin
            do b = 8'($urandom); while (is_escape_letter(b));
            send_byte(b, 1'b0);
         end
         1: send_byte(8'h00, 1'b1);
         default: begin
            send_byte("u", 1'b0);
            ndig = $urandom_range(0, 3);
            repeat (ndig) send_byte(hex_char(4'($urandom)), 1'b0);
            if ($urandom_range(0, 2) == 0) send_byte(8'h00, 1'b1);
            else begin
               do b = 8'($urandom); while (decode_scoreboard_type::hex_nibble(b) >= 0);
               send_byte(b, 1'b0);
            end
         end
      endcase
   endtask

   task automatic send_string();
      logic [7:0] b;
      int nws;
      int nparts;
      int pick;
      bit broken;
      logic [7:0] simple_esc [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
      logic [7:0] ws_set [6] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
      broken = 1'b0;
      nws = $urandom_range(0, 2);
      repeat (nws) send_byte(ws_set[$urandom_range(0, 5)], 1'b0);
      if ($urandom_range(0, 11) == 0) send_byte(8'($urandom), 1'b0);
      if ($urandom_range(0, 15) == 0) send_byte(8'h00, 1'b1);
      send_byte("\"", 1'b0);
      nparts = $urandom_range(0, 8);
      for (int i = 0; i < nparts && !broken; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            do b = 8'($urandom); while (b == "\"" || b == "\\");
            send_byte(b, 1'b0);
         end else if (pick < 65) begin
            send_byte("\\", 1'b0);
            send_byte(simple_esc[$urandom_range(0, 7)], 1'b0);
         end else if (pick < 92) send_unicode();
         else begin
            send_broken_escape();
            broken = 1'b1;
         end
      end
      if (!broken) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) send_byte("\"", 1'b0);
         else if (pick < 95) send_byte(8'h00, 1'b1);
      end
   endtask

   // result side back-pressure
   initial begin
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("json_string_unescape_tb: done, errors");
         $finish;
      end
   end

   initial begin
      // whitespace, stray byte, end in idle, byte extremes, unknown escape,
      // escape cut off, 3-byte unicode, bad hex digit, unterminated string,
      // end of text inside hex digits
      logic [8:0] directed [] = '{
         9'h020, 9'h078, EOT, 9'h022, 9'h000, 9'h0FF, 9'h05C, 9'h071,
         9'h022, 9'h05C, EOT, 9'h022, 9'h05C, 9'h075, 9'h046, 9'h066,
         9'h066, 9'h066, 9'h05C, 9'h075, 9'h067, 9'h022, EOT, 9'h022,
         9'h05C, 9'h075, 9'h030, EOT};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
      while (bytes_sent < NUM_ITEMS) begin
         if (bytes_sent >= QUIET_AFTER) quiet = 1'b1;
         send_string();
      end
      req_tvalid <= 1'b0;
      while (sb.decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("sent %0d text bytes, checked %0d results", bytes_sent, sb.checked);
      $display("of those %0d string completions and %0d error results",
               sb.completions, sb.error_results);
      if (sb.errors == 0) $display("json_string_unescape_tb: done, clean");
      else $display("json_string_unescape_tb: done, errors");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/jsu_pkg.sv
hw/rtl/json_string_unescape.sv
verif/json_string_unescape_tb.sv
